### src/cmbc_pkg.sv
// ----------------------------------------------------------------------------
// cmbc_pkg
// shared types and constants of the cartridge memory bank controller
// ----------------------------------------------------------------------------
package cmbc_pkg;

  // external ram size in bytes
  localparam int CMBC_RAM_BYTES = 32768;

  // field and register widths
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_BASE_W = 21;
  localparam int RAM_BASE_W = 15;
  localparam int ROM_BANK_W = 7;
  localparam int RAM_BANK_W = 2;
  localparam int ROM_CNT_W  = 8;
  localparam int RAM_CNT_W  = 3;
  localparam int DIV_W      = 9;   // divisor incl. the 256 case
  localparam int UNIT_W     = 16;  // shared subtractor operand width
  localparam int STEP_W     = 3;

  // restoring remainder: one step per dividend bit
  localparam int DIV_STEPS  = ROM_BANK_W;

  // control address regions (upper bounds)
  localparam logic [ADDR_W-1:0] RGN_ENABLE_TOP = 16'h1FFF;
  localparam logic [ADDR_W-1:0] RGN_ROM_LO_TOP = 16'h3FFF;
  localparam logic [ADDR_W-1:0] RGN_BANK2_TOP  = 16'h5FFF;

  localparam logic [3:0]        RAM_ENABLE_KEY = 4'hA;
  localparam logic [DATA_W-1:0] READ_DISABLED  = 8'hFF;

  typedef enum logic [1:0] {
    KIND_CTRL  = 2'd0,
    KIND_RD    = 2'd1,
    KIND_WR    = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_ROM_COUNT = 1'b0,
    CFG_RAM_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WRAP,
    ST_MEM,
    ST_RESP
  } state_t;

endpackage

### src/cmbc_ram.sv
// ----------------------------------------------------------------------------
// cmbc_ram
// generic single-port ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module cmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

### src/cartridge_memory_bank_controller_core.sv
// sequence: ST_EXEC, then 7 remainder steps in ST_DIV for rom/ram bank writes, or index wrap
//   steps in ST_WRAP and ST_MEM for enabled ram reads/writes, then ST_RESP for every word
// a new word is taken only in ST_IDLE; busy stays high until the strobe cycle ends
// remainder and wrap steps go through one shared 16-bit subtract/compare unit, one step per cycle
// results come out for one cycle on out_strobe; the receiver cannot stall
// reset (rst_n low, synchronous): bank 1, ram bank 0, mode 0, ram off, counts 128 and 4
// ----------------------------------------------------------------------------
// cartridge_memory_bank_controller_core
// mbc1-style bank controller: control writes, banked external ram access,
// bank base recompute by an iterative remainder on a shared subtractor
// ----------------------------------------------------------------------------
module cartridge_memory_bank_controller_core #(
  parameter int RAM_BYTES = cmbc_pkg::CMBC_RAM_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [cmbc_pkg::ROM_CNT_W-1:0]   cfg_data,
  // command
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_mode,
  input  logic [cmbc_pkg::ADDR_W-1:0]      in_addr,
  input  logic [cmbc_pkg::DATA_W-1:0]      in_data,
  // result
  output logic                             out_strobe,
  output logic [cmbc_pkg::DATA_W-1:0]      out_read_data,
  output logic [cmbc_pkg::ROM_BASE_W-1:0]  out_rom_base,
  output logic [cmbc_pkg::RAM_BASE_W-1:0]  out_ram_base,
  output logic                             out_ram_on
);

  import cmbc_pkg::*;

  localparam int AW = $clog2(RAM_BYTES);

  // sequencer
  state_t state_r, state_nxt;

  // configuration registers
  logic [ROM_CNT_W-1:0] rom_cnt_r, rom_cnt_nxt;
  logic [RAM_CNT_W-1:0] ram_cnt_r, ram_cnt_nxt;

  // architectural bank state
  logic [ROM_BANK_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r, ram_bank_nxt;
  logic                  bank_mode_r, bank_mode_nxt;
  logic                  ram_en_r, ram_en_nxt;
  logic [ROM_BASE_W-1:0] rom_base_r, rom_base_nxt;
  logic [RAM_BASE_W-1:0] ram_base_r, ram_base_nxt;

  // captured command word
  logic [1:0]        mode_r, mode_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  // working registers of the shared unit
  logic [ROM_BANK_W-1:0] dvd_r, dvd_nxt;     // dividend, shifted out msb first
  logic [DIV_W-1:0]      div_r, div_nxt;     // divisor (bank count, 0 as full)
  logic [7:0]            rem_r, rem_nxt;     // partial remainder
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  sel_rom_r, sel_rom_nxt;
  logic [RAM_BASE_W-1:0] idx_r, idx_nxt;     // ram byte index before wrap

  // result staging
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic              rd_mem_r, rd_mem_nxt;

  // decode flags for the sequencer
  logic exec_div, exec_mem, div_last, wrap_done;

  // shared subtract/compare unit
  logic [UNIT_W-1:0] op_a, op_b;
  logic [UNIT_W:0]   unit_diff;
  logic              unit_ge;
  logic [7:0]        rem_step;

  // control write helpers
  logic [4:0]            low_bits;
  logic [ROM_BANK_W-1:0] rom_bank_new;
  logic [DIV_W-1:0]      rom_div, ram_div;

  // ram port
  logic              ram_we;
  logic [DATA_W-1:0] ram_q;

  // ---------------------------------------------------------------------------
  // shared unit: one subtract and borrow check per cycle
  // remainder step in ST_DIV, modulo-ram-size step in ST_WRAP
  // ---------------------------------------------------------------------------
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_DIV: begin
        op_a = {{(UNIT_W-9){1'b0}}, rem_r, dvd_r[ROM_BANK_W-1]};
        op_b = {{(UNIT_W-DIV_W){1'b0}}, div_r};
      end
      ST_WRAP: begin
        op_a = {{(UNIT_W-RAM_BASE_W){1'b0}}, idx_r};
        op_b = UNIT_W'(RAM_BYTES);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign unit_diff = {1'b0, op_a} - {1'b0, op_b};
  assign unit_ge   = ~unit_diff[UNIT_W];
  assign rem_step  = unit_ge ? unit_diff[7:0] : op_a[7:0];

  // bank counts of zero mean no wrap
  assign rom_div  = (rom_cnt_r == '0) ? DIV_W'(256) : {1'b0, rom_cnt_r};
  assign ram_div  = (ram_cnt_r == '0) ? DIV_W'(8)   : {{(DIV_W-RAM_CNT_W){1'b0}}, ram_cnt_r};

  // low five rom bank bits, zero selects bank one
  assign low_bits = (data_r[4:0] == 5'd0) ? 5'd1 : data_r[4:0];

  // ---------------------------------------------------------------------------
  // datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    rom_cnt_nxt   = rom_cnt_r;
    ram_cnt_nxt   = ram_cnt_r;
    rom_bank_nxt  = rom_bank_r;
    ram_bank_nxt  = ram_bank_r;
    bank_mode_nxt = bank_mode_r;
    ram_en_nxt    = ram_en_r;
    rom_base_nxt  = rom_base_r;
    ram_base_nxt  = ram_base_r;
    mode_nxt      = mode_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    dvd_nxt       = dvd_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    sel_rom_nxt   = sel_rom_r;
    idx_nxt       = idx_r;
    rd_nxt        = rd_r;
    rd_mem_nxt    = rd_mem_r;
    rom_bank_new  = rom_bank_r;
    exec_div      = 1'b0;
    exec_mem      = 1'b0;
    div_last      = 1'b0;
    wrap_done     = 1'b0;

    // configuration is to be written only while idle; the block itself does not enforce it
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROM_COUNT: rom_cnt_nxt = cfg_data;
        CFG_RAM_COUNT: ram_cnt_nxt = cfg_data[RAM_CNT_W-1:0];
        default:       rom_cnt_nxt = rom_cnt_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          addr_nxt = in_addr;
          data_nxt = in_data;
        end
      end

      ST_EXEC: begin
        rd_nxt     = '0;
        rd_mem_nxt = 1'b0;
        unique case (kind_t'(mode_r))
          KIND_CTRL: begin
            if (addr_r <= RGN_ENABLE_TOP) begin
              ram_en_nxt = (data_r[3:0] == RAM_ENABLE_KEY);
            end else if (addr_r <= RGN_ROM_LO_TOP) begin
              // mode 1 drops the upper two bits
              rom_bank_new = bank_mode_r ? {2'b00, low_bits} : {rom_bank_r[6:5], low_bits};
              exec_div     = 1'b1;
              sel_rom_nxt  = 1'b1;
            end else if (addr_r <= RGN_BANK2_TOP) begin
              if (bank_mode_r) begin
                ram_bank_nxt = data_r[1:0];
                exec_div     = 1'b1;
                sel_rom_nxt  = 1'b0;
              end else begin
                rom_bank_new = {data_r[1:0], rom_bank_r[4:0]};
                exec_div     = 1'b1;
                sel_rom_nxt  = 1'b1;
              end
            end else begin
              bank_mode_nxt = data_r[0];
            end
            rom_bank_nxt = rom_bank_new;
            if (exec_div) begin
              rem_nxt  = '0;
              step_nxt = STEP_W'(DIV_STEPS);
              if (sel_rom_nxt) begin
                dvd_nxt = rom_bank_new;
                div_nxt = rom_div;
              end else begin
                dvd_nxt = {{(ROM_BANK_W-RAM_BANK_W){1'b0}}, data_r[1:0]};
                div_nxt = ram_div;
              end
            end
          end
          KIND_RD: begin
            if (ram_en_r) begin
              exec_mem   = 1'b1;
              rd_mem_nxt = 1'b1;
              idx_nxt    = ram_base_r + {2'b00, addr_r[12:0]};
            end else begin
              rd_nxt = READ_DISABLED;
            end
          end
          KIND_WR: begin
            if (ram_en_r) begin
              exec_mem = 1'b1;
              idx_nxt  = ram_base_r + {2'b00, addr_r[12:0]};
            end
          end
          KIND_NONE: begin
            rd_nxt = '0;
          end
          default: rd_nxt = '0;
        endcase
      end

      ST_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[ROM_BANK_W-2:0], 1'b0};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          div_last = 1'b1;
          if (sel_rom_r) begin
            rom_base_nxt = {rem_step[6:0], 14'b0};
          end else begin
            ram_base_nxt = {rem_step[1:0], 13'b0};
          end
        end
      end

      ST_WRAP: begin
        if (unit_ge) begin
          idx_nxt = unit_diff[RAM_BASE_W-1:0];
        end else begin
          wrap_done = 1'b1;
        end
      end

      default: begin
        rd_nxt = rd_r;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start)     state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (exec_div) begin
          state_nxt = ST_DIV;
        end else if (exec_mem) begin
          state_nxt = ST_WRAP;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_DIV:  if (div_last)  state_nxt = ST_RESP;
      ST_WRAP: if (wrap_done) state_nxt = ST_MEM;
      ST_MEM:                 state_nxt = ST_RESP;
      ST_RESP:                state_nxt = ST_IDLE;
      default:                state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    busy       = 1'b1;
    out_strobe = 1'b0;
    ram_we     = 1'b0;
    unique case (state_r)
      ST_IDLE: busy       = 1'b0;
      ST_MEM:  ram_we     = (kind_t'(mode_r) == KIND_WR);
      ST_RESP: out_strobe = 1'b1;
      default: busy       = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rom_cnt_r   <= ROM_CNT_W'(128);
      ram_cnt_r   <= RAM_CNT_W'(4);
      rom_bank_r  <= ROM_BANK_W'(1);
      ram_bank_r  <= '0;
      bank_mode_r <= 1'b0;
      ram_en_r    <= 1'b0;
      rom_base_r  <= ROM_BASE_W'(16384);
      ram_base_r  <= '0;
      rd_r        <= '0;
      rd_mem_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rom_cnt_r   <= rom_cnt_nxt;
      ram_cnt_r   <= ram_cnt_nxt;
      rom_bank_r  <= rom_bank_nxt;
      ram_bank_r  <= ram_bank_nxt;
      bank_mode_r <= bank_mode_nxt;
      ram_en_r    <= ram_en_nxt;
      rom_base_r  <= rom_base_nxt;
      ram_base_r  <= ram_base_nxt;
      rd_r        <= rd_nxt;
      rd_mem_r    <= rd_mem_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    addr_r    <= addr_nxt;
    data_r    <= data_nxt;
    dvd_r     <= dvd_nxt;
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    sel_rom_r <= sel_rom_nxt;
    idx_r     <= idx_nxt;
  end

  // ---------------------------------------------------------------------------
  // external ram store, read data lands in ST_RESP
  // ---------------------------------------------------------------------------
  cmbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (idx_r[AW-1:0]),
    .wdata (data_r),
    .rdata (ram_q)
  );

  // result word
  assign out_read_data = rd_mem_r ? ram_q : rd_r;
  assign out_rom_base  = rom_base_r;
  assign out_ram_base  = ram_base_r;
  assign out_ram_on    = ram_en_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  a_idle_after_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_strobe))
    else $error("busy dropped without a result strobe");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ({1'b0, rem_r} < div_r))
    else $error("partial remainder not below divisor");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MEM) |-> ({1'b0, idx_r} < 16'(RAM_BYTES)))
    else $error("ram index not wrapped");

  a_write_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ram_en_r)
    else $error("ram write while ram disabled");

endmodule
